// ----- src/bitmap_block_allocator_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Check a property on every rising edge while reset is released.
`define BBA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bitmap allocator check failed");

// Check a property on every rising edge, reset included.
`define BBA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bitmap allocator check failed");

`endif

// ----- src/bba_pkg.sv -----
package bba_pkg;

    localparam int MAX_BLOCKS_DEFAULT = 256;

    // blocks per map row
    localparam int ROW_BITS  = 8;
    localparam int ROW_SHIFT = 3;

    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 24;
    localparam int BSIZE_W = 16;
    localparam int BCOUNT_W = 9;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BSIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BCOUNT = 2'd2;

    localparam logic [ADDR_W-1:0]   BASE_RESET   = 32'h0;
    localparam logic [BSIZE_W-1:0]  BSIZE_RESET  = 16'd64;
    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 9'd256;

endpackage

// ----- src/bitmap_block_allocator_unit.sv -----
// Bitmap first-fit block allocator.
// Input channel s_*: one request per transfer (allocate or free, byte size,
// address to free). Result channel m_*: one status and granted address per
// request, in request order. Configuration (base, block size, block count)
// is to be written through cfg_we/cfg_index/cfg_wdata only while the block is idle;
// the block itself does not enforce this. The map sits in a RAM of 8-block rows;
// each row is read and then evaluated, or read and then written back when marked.
// A request rejected up front goes straight to the hand-off; any other passes the
// rounding division (a free then divides the address offset as well), then the
// rows are scanned or checked and the rows marked, and for an allocate the granted
// address is formed by a multiply and an add before the hand-off.
// One request is processed at a time; the next one is accepted once the
// result sits in the output register, even if the receiver stalls it.
// A stalled result holds; a further finished result waits until it is taken.
// After reset the map is cleared one row a cycle with s_ready low; configuration
// writes are taken throughout.
module bitmap_block_allocator_unit import bba_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_func,
    input  logic [BYTES_W-1:0]   s_request_bytes,
    input  logic [ADDR_W-1:0]    s_buffer_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [ADDR_W-1:0]    m_granted_address
);

    localparam int ROWS = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW = RW + ROW_SHIFT + 1;
    localparam int PW = XW + BSIZE_W;
    localparam int NEED_W = BYTES_W + 1;
    localparam int DIV_STEPS = ADDR_W;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [XW-1:0] MAX_X = XW'(MAX_BLOCKS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIV, S_DIVEND, S_SC_RD, S_SC_EV, S_CK_RD, S_CK_EV,
        S_MK_RD, S_MK_WR, S_MUL, S_ADD, S_FIN
    } state_t;

    state_t state_reg;

    logic [ADDR_W-1:0]   base_reg;
    logic [BSIZE_W-1:0]  bsize_reg;
    logic [BCOUNT_W-1:0] bcount_reg;

    logic                func_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [NEED_W-1:0]   need_reg;

    logic [ADDR_W-1:0]   dvd_reg;
    logic [BSIZE_W:0]    rem_reg;
    logic [ADDR_W-1:0]   quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                div_sel_reg;

    logic [RW-1:0]       row_reg;
    logic [XW-1:0]       run_reg;
    logic [XW-1:0]       start_reg;
    logic [XW-1:0]       lo_reg;
    logic [XW-1:0]       hi_reg;
    logic                mark_set_reg;
    logic [PW-1:0]       prod_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ADDR_W-1:0]   m_addr_reg;

    logic                ram_we;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROW_BITS-1:0] ram_rdata;

    logic [XW-1:0]       n_x;
    logic [ADDR_W-1:0]   n32;
    logic [RW-1:0]       last_row;
    logic [RW-1:0]       hi_row;
    logic [BSIZE_W:0]    rem_sh;
    logic                rem_ge;
    logic [NEED_W-1:0]   need_comb;
    logic [ROW_BITS-1:0] win_mask;
    logic                ck_bad;
    logic [XW-1:0]       run_v;
    logic [XW-1:0]       start_v;
    logic [XW-1:0]       end_v;
    logic                fnd_v;
    logic                trivial_bad;

    bba_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(ROWS)
    ) u_map (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(row_reg),
        .wdata(ram_wdata),
        .raddr(row_reg),
        .rdata(ram_rdata)
    );

    assign n_x = (32'(bcount_reg) > 32'(MAX_BLOCKS)) ? MAX_X : XW'(bcount_reg);
    assign n32 = 32'(n_x);
    assign last_row = RW'((n_x - XW'(1)) >> ROW_SHIFT);
    assign hi_row = RW'(hi_reg >> ROW_SHIFT);
    assign rem_sh = {rem_reg[BSIZE_W-1:0], dvd_reg[ADDR_W-1]};
    assign rem_ge = rem_sh >= {1'b0, bsize_reg};
    assign need_comb = NEED_W'(quo_reg) + NEED_W'(rem_reg != '0);
    assign ck_bad = |(win_mask & ~ram_rdata);
    assign trivial_bad = (bsize_reg == '0) || (s_request_bytes == '0) || (n_x == '0);

    always_comb begin
        logic [XW-1:0] idx;
        win_mask = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            idx = XW'({row_reg, 3'(b)});
            win_mask[b] = (idx >= lo_reg) && (idx <= hi_reg);
        end
    end

    always_comb begin
        logic [XW-1:0] idx;
        run_v = run_reg;
        start_v = start_reg;
        end_v = '0;
        fnd_v = 1'b0;
        for (int b = 0; b < ROW_BITS; b++) begin
            idx = XW'({row_reg, 3'(b)});
            if ((idx < n_x) && !fnd_v) begin
                if (ram_rdata[b]) begin
                    run_v = '0;
                end else begin
                    if (run_v == '0) begin
                        start_v = idx;
                    end
                    run_v = run_v + XW'(1);
                    if (32'(run_v) >= 32'(need_reg)) begin
                        fnd_v = 1'b1;
                        end_v = idx;
                    end
                end
            end
        end
    end

    always_comb begin
        ram_we = 1'b0;
        ram_wdata = '0;
        if (state_reg == S_CLR) begin
            ram_we = 1'b1;
        end else if (state_reg == S_MK_WR) begin
            ram_we = 1'b1;
            ram_wdata = mark_set_reg ? (ram_rdata | win_mask) : (ram_rdata & ~win_mask);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
            bsize_reg <= BSIZE_RESET;
            bcount_reg <= BCOUNT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BASE:   base_reg <= cfg_wdata;
                REG_BSIZE:  bsize_reg <= cfg_wdata[BSIZE_W-1:0];
                REG_BCOUNT: bcount_reg <= cfg_wdata[BCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            row_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_FIN) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR: begin
                    if (row_reg == LAST_ROW) begin
                        row_reg <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        row_reg <= row_reg + RW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        func_reg <= s_func;
                        addr_reg <= s_buffer_address;
                        res_addr_reg <= '0;
                        if (trivial_bad) begin
                            res_status_reg <= (s_func == FUNC_ALLOC) ? ST_NO_SPACE
                                                                     : ST_BAD_FREE;
                            state_reg <= S_FIN;
                        end else if ((s_func == FUNC_FREE) && (s_buffer_address < base_reg)) begin
                            res_status_reg <= ST_BAD_FREE;
                            state_reg <= S_FIN;
                        end else begin
                            dvd_reg <= ADDR_W'(s_request_bytes);
                            rem_reg <= '0;
                            quo_reg <= '0;
                            cnt_reg <= '0;
                            div_sel_reg <= 1'b0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_ge ? (rem_sh - {1'b0, bsize_reg}) : rem_sh;
                    quo_reg <= {quo_reg[ADDR_W-2:0], rem_ge};
                    dvd_reg <= {dvd_reg[ADDR_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= S_DIVEND;
                    end
                end
                S_DIVEND: begin
                    if (!div_sel_reg) begin
                        need_reg <= need_comb;
                        if (func_reg == FUNC_ALLOC) begin
                            if (32'(need_comb) > n32) begin
                                res_status_reg <= ST_NO_SPACE;
                                state_reg <= S_FIN;
                            end else begin
                                row_reg <= '0;
                                run_reg <= '0;
                                start_reg <= '0;
                                state_reg <= S_SC_RD;
                            end
                        end else begin
                            dvd_reg <= addr_reg - base_reg;
                            rem_reg <= '0;
                            quo_reg <= '0;
                            cnt_reg <= '0;
                            div_sel_reg <= 1'b1;
                            state_reg <= S_DIV;
                        end
                    end else begin
                        if ((quo_reg >= n32) || (32'(need_reg) > (n32 - quo_reg))) begin
                            res_status_reg <= ST_BAD_FREE;
                            state_reg <= S_FIN;
                        end else begin
                            lo_reg <= XW'(quo_reg);
                            hi_reg <= XW'(quo_reg + 32'(need_reg) - 32'd1);
                            row_reg <= RW'(quo_reg >> ROW_SHIFT);
                            state_reg <= S_CK_RD;
                        end
                    end
                end
                S_SC_RD: state_reg <= S_SC_EV;
                S_SC_EV: begin
                    run_reg <= run_v;
                    start_reg <= start_v;
                    if (fnd_v) begin
                        lo_reg <= start_v;
                        hi_reg <= end_v;
                        row_reg <= RW'(start_v >> ROW_SHIFT);
                        mark_set_reg <= 1'b1;
                        state_reg <= S_MK_RD;
                    end else if (row_reg == last_row) begin
                        res_status_reg <= ST_NO_SPACE;
                        state_reg <= S_FIN;
                    end else begin
                        row_reg <= row_reg + RW'(1);
                        state_reg <= S_SC_RD;
                    end
                end
                S_CK_RD: state_reg <= S_CK_EV;
                S_CK_EV: begin
                    if (ck_bad) begin
                        res_status_reg <= ST_BAD_FREE;
                        state_reg <= S_FIN;
                    end else if (row_reg == hi_row) begin
                        row_reg <= RW'(lo_reg >> ROW_SHIFT);
                        mark_set_reg <= 1'b0;
                        state_reg <= S_MK_RD;
                    end else begin
                        row_reg <= row_reg + RW'(1);
                        state_reg <= S_CK_RD;
                    end
                end
                S_MK_RD: state_reg <= S_MK_WR;
                S_MK_WR: begin
                    if (row_reg == hi_row) begin
                        if (mark_set_reg) begin
                            state_reg <= S_MUL;
                        end else begin
                            res_status_reg <= ST_OK;
                            state_reg <= S_FIN;
                        end
                    end else begin
                        row_reg <= row_reg + RW'(1);
                        state_reg <= S_MK_RD;
                    end
                end
                S_MUL: begin
                    prod_reg <= PW'(lo_reg) * PW'(bsize_reg);
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    res_addr_reg <= base_reg + ADDR_W'(prod_reg);
                    res_status_reg <= ST_OK;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_status_reg <= res_status_reg;
                        m_addr_reg <= res_addr_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_CLR;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_granted_address = m_addr_reg;

endmodule

// ----- src/bba_ram.sv -----
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/bba_checker.sv -----
`include "bitmap_block_allocator_unit_defines.svh"

module bba_checker import bba_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [ADDR_W-1:0]   m_granted_address
);

    `BBA_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_granted_address))
    `BBA_ASSERT(a_addr_zero, aclk, aresetn, m_valid && (m_status != ST_OK) |-> m_granted_address == '0)
    `BBA_ASSERT(a_status_code, aclk, aresetn, m_valid |-> (m_status == ST_OK) || (m_status == ST_NO_SPACE) || (m_status == ST_BAD_FREE))
    `BBA_ASSERT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    `BBA_ASSERT_ALWAYS(a_clear_after_reset, aclk, !aresetn |=> !s_ready)

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);

// ----- tb/bitmap_block_allocator_unit_tb.sv -----
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_tb;
    import bba_pkg::*;

    typedef struct packed {
        logic               func;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  addr;
    } alloc_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   granted;
    } alloc_rsp_t;

    localparam int NBLK = MAX_BLOCKS_DEFAULT;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_func;
    logic [BYTES_W-1:0]   s_request_bytes;
    logic [ADDR_W-1:0]    s_buffer_address;
    logic                 m_valid;
    logic                 m_ready;
    logic [STATUS_W-1:0]  m_status;
    logic [ADDR_W-1:0]    m_granted_address;

    bitmap_block_allocator_unit u_top (.*);

    logic [31:0] mdl_base;
    logic [31:0] mdl_bsize;
    logic [31:0] mdl_bcount;
    bit          mdl_map [NBLK];

    alloc_req_t  pending_reqs [$];
    alloc_rsp_t  expected_rsps [$];
    logic [31:0] granted_list [$];
    longint      cycle_cnt = 0;
    int          mismatches = 0;
    int          rsp_seen = 0;
    int          n_ok, n_nospace, n_badfree;
    int          drv_wait;
    int          mon_wait;
    int          hold_off = 0;
    bit          hold_start = 1'b0;
    bit          drain_req;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] blocks_needed(logic [63:0] nbytes);
        return (nbytes + mdl_bsize - 1) / mdl_bsize;
    endfunction

    function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
        alloc_rsp_t  rsp;
        logic [31:0] n;
        logic [63:0] need;
        int          run;
        int          start;
        n = (mdl_bcount > NBLK) ? NBLK : mdl_bcount;
        run = 0;
        start = 0;
        if (r.func == FUNC_ALLOC) begin
            rsp = '{ST_NO_SPACE, '0};
            if (mdl_bsize == 0 || r.bytes == 0 || n == 0) return rsp;
            need = blocks_needed(r.bytes);
            if (need > n) return rsp;
            for (int i = 0; i < n; i++) begin
                if (mdl_map[i]) begin
                    run = 0;
                end else begin
                    if (run == 0) start = i;
                    run++;
                    if (run >= need) begin
                        for (int k = start; k <= i; k++) mdl_map[k] = 1'b1;
                        rsp.status = ST_OK;
                        rsp.granted = 32'(64'(mdl_base) + 64'(start) * 64'(mdl_bsize));
                        return rsp;
                    end
                end
            end
            return rsp;
        end else begin
            logic [63:0] first;
            rsp = '{ST_BAD_FREE, '0};
            if (mdl_bsize == 0 || r.bytes == 0 || n == 0) return rsp;
            if (r.addr < mdl_base) return rsp;
            first = (64'(r.addr) - 64'(mdl_base)) / 64'(mdl_bsize);
            need = blocks_needed(r.bytes);
            if (first >= n || need > 64'(n) - first) return rsp;
            for (longint k = first; k < first + need; k++)
                if (!mdl_map[k]) return rsp;
            for (longint k = first; k < first + need; k++) mdl_map[k] = 1'b0;
            rsp.status = ST_OK;
            return rsp;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_func <= 1'b0;
            s_request_bytes <= '0;
            s_buffer_address <= '0;
            drv_wait <= 0;
        end else if (s_valid && !s_ready) begin
        end else if (drv_wait > 0) begin
            s_valid <= 1'b0;
            drv_wait <= drv_wait - 1;
        end else if (pending_reqs.size() > 0 && !drain_req) begin
            alloc_req_t r;
            r = pending_reqs.pop_front();
            expected_rsps.push_back(predict_alloc(r));
            s_valid <= 1'b1;
            s_func <= r.func;
            s_request_bytes <= r.bytes;
            s_buffer_address <= r.addr;
            drv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // long receiver stall
    always @(posedge aclk) begin
        if (hold_start) begin
            hold_off <= 400;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
            mon_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                alloc_rsp_t e;
                rsp_seen <= rsp_seen + 1;
                if (expected_rsps.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected transfer: status %0d addr %h",
                                 m_status, m_granted_address);
                end else begin
                    e = expected_rsps.pop_front();
                    if (e.status == ST_OK && m_status == ST_OK) n_ok++;
                    if (e.status == ST_NO_SPACE) n_nospace++;
                    if (e.status == ST_BAD_FREE) n_badfree++;
                    if (m_status !== e.status || m_granted_address !== e.granted) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: exp status %0d addr %h, got %0d %h",
                                     e.status, e.granted, m_status, m_granted_address);
                    end else if (e.status == ST_OK && e.granted != 0) begin
                        granted_list.push_back(e.granted);
                    end
                end
            end
            if (hold_off > 0) begin
                m_ready <= 1'b0;
            end else if (mon_wait > 0) begin
                m_ready <= 1'b0;
                mon_wait <= mon_wait - 1;
            end else if (m_valid && m_ready) begin
                m_ready <= 1'b0;
                mon_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == REG_BASE) mdl_base = val;
        else if (idx == REG_BSIZE) mdl_bsize = val[15:0];
        else if (idx == REG_BCOUNT) mdl_bcount = val[8:0];
    endtask

    task automatic configure(logic [31:0] b, logic [31:0] sz, logic [31:0] cnt);
        wait_idle();
        write_reg(REG_BASE, b);
        write_reg(REG_BSIZE, sz);
        write_reg(REG_BCOUNT, cnt);
        write_reg(2'd3, $urandom);
        cfg_we <= 1'b0;
    endtask

    task automatic push_req(logic f, logic [BYTES_W-1:0] nb, logic [31:0] a);
        pending_reqs.push_back('{f, nb, a});
    endtask

    task automatic random_phase(int count);
        logic [31:0] a;
        int          sel;
        logic [63:0] span;
        for (int i = 0; i < count; i++) begin
            span = 64'(mdl_bsize == 0 ? 1 : mdl_bsize);
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                push_req(FUNC_ALLOC, BYTES_W'($urandom_range(1, 32'(span) * 6)), $urandom);
            end else if (sel < 80 && granted_list.size() > 0) begin
                a = granted_list[$urandom_range(0, granted_list.size() - 1)];
                push_req(FUNC_FREE, BYTES_W'($urandom_range(1, 32'(span) * 3)),
                         a + $urandom_range(0, 1));
            end else if (sel < 90) begin
                push_req(FUNC_FREE, BYTES_W'($urandom_range(1, 32'(span) * 4)),
                         mdl_base + $urandom_range(0, 32'(span) * 40));
            end else begin
                push_req($urandom_range(0, 1), BYTES_W'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        drain_req = 1'b0;
        mdl_base = BASE_RESET;
        mdl_bsize = BSIZE_RESET;
        mdl_bcount = BCOUNT_RESET;
        foreach (mdl_map[i]) mdl_map[i] = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_req(FUNC_ALLOC, 24'd1, 32'h0);
        push_req(FUNC_ALLOC, 24'd64, 32'h0);
        push_req(FUNC_ALLOC, 24'd65, 32'h0);
        push_req(FUNC_ALLOC, 24'd0, 32'h0);
        push_req(FUNC_ALLOC, 24'hFFFFFF, 32'hFFFFFFFF);
        push_req(FUNC_FREE, 24'd64, 32'd64);
        push_req(FUNC_FREE, 24'd64, 32'd64);
        push_req(FUNC_FREE, 24'd0, 32'd0);
        push_req(FUNC_FREE, 24'd1, 32'd130);
        push_req(FUNC_FREE, 24'd64, 32'hFFFFFFFF);
        push_req(FUNC_ALLOC, 24'd64 * 256, 32'h0);
        push_req(FUNC_FREE, 24'hFFFFFF, 32'd0);
        push_req(FUNC_ALLOC, 24'd256 * 64 - 64 * 4, 32'h0);
        push_req(FUNC_FREE, 24'd64 * 5, 32'd0);
        random_phase(100);

        // fill the block: long receiver stall while sender keeps offering
        wait (pending_reqs.size() < 50);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        wait_idle();

        configure(32'hFFFF_FF00, 16'd1, 9'd0);
        push_req(FUNC_ALLOC, 24'd1, 32'h0);
        push_req(FUNC_FREE, 24'd1, 32'hFFFF_FF00);
        configure(32'hFFFF_F000, 16'd0, 9'd16);
        push_req(FUNC_ALLOC, 24'd1, 32'h0);
        push_req(FUNC_FREE, 24'd1, 32'hFFFF_F000);
        configure(32'hFFFF_F000, 16'hFFFF, 9'd8);
        push_req(FUNC_ALLOC, 24'h20000, 32'h0);
        push_req(FUNC_ALLOC, 24'h20000, 32'h0);
        push_req(FUNC_ALLOC, 24'hFFFFFF, 32'h0);
        random_phase(100);
        configure(32'h1000_0000, 16'd48, 9'd300 & 9'h1FF);
        random_phase(150);
        configure(32'h0, 16'd1, 9'd256);
        random_phase(100);

        // sender pause until drained
        drain_req = 1'b1;
        wait (expected_rsps.size() == 0);
        drain_req = 1'b0;

        configure($urandom, 16'($urandom_range(1, 300)), 9'($urandom_range(1, 64)));
        random_phase(150);
        configure(32'h8000_0000, 16'd7, 9'd1);
        random_phase(50);
        configure(32'h0000_0040, 16'd64, 9'd256);
        random_phase(150);

        wait_idle();
        $display("Covered %0d transfers: %0d ok, %0d no space, %0d bad free",
                 rsp_seen, n_ok, n_nospace, n_badfree);
        $display("Configurations swept block size 0..65535, block count 0..256, wrap");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/bitmap_block_allocator_unit.sv
src/bba_checker.sv
tb/bitmap_block_allocator_unit_tb.sv
